// ===== sv/ptt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the page table translator.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int FRAME_BITS  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VA_W        = 31;
    localparam int PA_W        = 32;
    localparam int SHIFT_W     = 5;
    localparam int COUNT_W     = 7;
    localparam int PFC_W       = 16;
    localparam int SIZE_W      = 2;
    localparam int EIDX_W      = 6;
    localparam int EFRAME_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SHIFT_W-1:0]    PAGE_SHIFT_RST = SHIFT_W'(7);
    localparam logic [COUNT_W-1:0]    PAGE_COUNT_RST = '0;
    localparam logic [PFC_W-1:0]      PHYS_FRAMES_RST = PFC_W'(32);

    localparam logic [CFG_IDX_W-1:0]  CFG_PAGE_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_PAGE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  CFG_PHYS_FRAMES = 2'd2;

    localparam logic [SIZE_W-1:0]     SZ_HALF = 2'd1;
    localparam logic [SIZE_W-1:0]     SZ_WORD = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_READ    = 2'd1,
        OP_WRITE   = 2'd2,
        OP_INSPECT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ADDR  = 3'd1,
        ST_FAULT = 3'd2,
        ST_PROT  = 3'd3,
        ST_BUS   = 3'd4
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_LOOKUP
    } back_state_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  valid;
        logic                  read_only;
        logic                  used;
        logic                  dirty;
    } pte_t;

    // classified item as handed from front to back
    typedef struct packed {
        op_t                   op;
        logic [IDX_W-1:0]      idx;
        logic                  page_err;
        logic                  align_err;
        logic [VA_W-1:0]       offset;
        logic [FRAME_BITS-1:0] frame;
        logic                  valid;
        logic                  read_only;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [PA_W-1:0]       phys_addr;
        pte_t                  entry;
    } res_t;

    localparam int PTE_W = $bits(pte_t);

endpackage
`default_nettype wire

// ===== sv/ptt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/ptt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_front
// Splits the virtual address, does range and alignment checks and queues
// the classified word for the back end.
// ----------------------------------------------------------------------------
module ptt_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     opcode,
    input  wire logic [ptt_pkg::VA_W-1:0]       virt_addr,
    input  wire logic [ptt_pkg::SIZE_W-1:0]     access_size,
    input  wire logic [ptt_pkg::EIDX_W-1:0]     entry_index,
    input  wire logic [ptt_pkg::EFRAME_W-1:0]   entry_frame,
    input  wire logic                           entry_valid,
    input  wire logic                           entry_read_only,
    input  wire logic [ptt_pkg::SHIFT_W-1:0]    page_shift,
    input  wire logic [ptt_pkg::COUNT_W-1:0]    page_count,
    output ptt_pkg::cmd_t                       head,
    output logic                                head_valid,
    input  wire logic                           pop
);
    import ptt_pkg::*;

    cmd_t               cls;
    logic [VA_W-1:0]    page;
    logic [VA_W-1:0]    off_mask;
    logic               is_access;
    logic               push;
    cmd_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    always_comb
    begin
        page      = virt_addr >> page_shift;
        off_mask  = ~({VA_W{1'b1}} << page_shift);
        is_access = (op_t'(opcode) == OP_READ) || (op_t'(opcode) == OP_WRITE);

        cls.op        = op_t'(opcode);
        cls.idx       = is_access ? page[IDX_W-1:0] : entry_index[IDX_W-1:0];
        cls.page_err  = (page >= VA_W'(TABLE_DEPTH)) || (page >= VA_W'(page_count));
        cls.align_err = ((access_size == SZ_HALF) && virt_addr[0])
                      || ((access_size >= SZ_WORD) && (virt_addr[1:0] != 2'b00));
        cls.offset    = virt_addr & off_mask;
        cls.frame     = entry_frame[FRAME_BITS-1:0];
        cls.valid     = entry_valid;
        cls.read_only = entry_read_only;
    end

    assign in_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ptt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_back
// Executes queued words against the page table: loads, lookups with mark
// update, and inspects. Holds the result register.
// ----------------------------------------------------------------------------
module ptt_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ptt_pkg::cmd_t                  head,
    input  wire logic                           head_valid,
    output logic                                pop,
    input  wire logic [ptt_pkg::SHIFT_W-1:0]    page_shift,
    input  wire logic [ptt_pkg::PFC_W-1:0]      phys_frame_count,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ptt_pkg::res_t                       res
);
    import ptt_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    cmd_t                   cmd_reg;
    cmd_t                   cmd_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic [TABLE_DEPTH-1:0] written_reg;
    logic [TABLE_DEPTH-1:0] written_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   res_reg;
    res_t                   res_next;
    logic                   out_free;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    pte_t                   ram_wdata;
    logic [PTE_W-1:0]       ram_rdata;
    pte_t                   entry;
    pte_t                   marked;
    logic [PA_W-1:0]        pa;
    logic                   is_wr;

    ptt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head.idx),
        .rdata (ram_rdata)
    );

    // entries never loaded since reset read as zero
    assign entry    = hit_reg ? pte_t'(ram_rdata) : '0;
    assign out_free = !out_valid_reg || res_ready;
    assign is_wr    = (cmd_reg.op == OP_WRITE);
    assign pa       = (PA_W'(entry.frame) << page_shift) + PA_W'(cmd_reg.offset);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        hit_next       = hit_reg;
        written_next   = written_reg;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = head.idx;
        ram_wdata      = '0;
        marked         = entry;

        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    hit_next = written_reg[head.idx];
                    res_next = '0;
                    case (head.op)
                        OP_LOAD:
                        begin
                            ram_we                 = 1'b1;
                            ram_wdata.frame        = head.frame;
                            ram_wdata.valid        = head.valid;
                            ram_wdata.read_only    = head.read_only;
                            written_next[head.idx] = 1'b1;
                            res_next.status        = ST_OK;
                            out_valid_next         = 1'b1;
                        end
                        OP_READ, OP_WRITE:
                        begin
                            if (head.page_err)
                            begin
                                res_next.status = ST_ADDR;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = BK_LOOKUP;
                            end
                        end
                        default:
                        begin
                            state_next = BK_LOOKUP;
                        end
                    endcase
                end
            end
            BK_LOOKUP:
            begin
                // result register is empty here: it was free when the word was popped
                state_next     = BK_IDLE;
                out_valid_next = 1'b1;
                res_next       = '0;
                ram_waddr      = cmd_reg.idx;
                if (cmd_reg.op == OP_INSPECT)
                begin
                    res_next.status = ST_OK;
                    res_next.entry  = entry;
                end
                else if (!entry.valid)
                begin
                    res_next.status = ST_FAULT;
                end
                else if (is_wr && entry.read_only)
                begin
                    res_next.status = ST_PROT;
                end
                else if (PFC_W'(entry.frame) >= phys_frame_count)
                begin
                    res_next.status = ST_BUS;
                end
                else
                begin
                    marked.used  = 1'b1;
                    marked.dirty = entry.dirty || is_wr;
                    ram_we       = 1'b1;
                    ram_wdata    = marked;
                    if (cmd_reg.align_err)
                    begin
                        res_next.status = ST_ADDR;
                    end
                    else
                    begin
                        res_next.status    = ST_OK;
                        res_next.phys_addr = pa;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// ===== sv/page_table_translator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_translator
// Single-level page table translation unit with 64 entries.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry an opcode: load entry, read access,
// write access or inspect entry. Each input word gives exactly one result
// word (out_valid/out_ready) with a status, a physical address for accesses
// and the entry contents for inspects.
// Configuration registers (page_shift, page_count, phys_frame_count) are
// written through cfg_we/cfg_index/cfg_data while the unit is idle, which
// the user must ensure: the unit does not enforce it. A two-deep queue
// separates the classifying front end from the table back end. In-range
// accesses and inspects, unlike loads, pass a lookup state that reads the
// table RAM; accesses passing the checks write the marks back. One load per
// cycle is taken while the receiver does not stall, none during a lookup.
// Reset clears every entry to invalid at once (per-entry written flags) and
// restores the register defaults. When the receiver stalls the result is
// held; the queue keeps taking words until it is full.
// ----------------------------------------------------------------------------
module page_table_translator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     opcode,
    input  wire logic [ptt_pkg::VA_W-1:0]       virt_addr,
    input  wire logic [ptt_pkg::SIZE_W-1:0]     access_size,
    input  wire logic [ptt_pkg::EIDX_W-1:0]     entry_index,
    input  wire logic [ptt_pkg::EFRAME_W-1:0]   entry_frame,
    input  wire logic                           entry_valid,
    input  wire logic                           entry_read_only,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          status,
    output logic [ptt_pkg::PA_W-1:0]            phys_addr,
    output logic [15:0]                         frame_out,
    output logic                                valid_out,
    output logic                                read_only_out,
    output logic                                used_out,
    output logic                                dirty_out,
    input  wire logic                           cfg_we,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptt_pkg::*;

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [COUNT_W-1:0] page_count_reg;
    logic [PFC_W-1:0]   phys_frames_reg;
    cmd_t               head;
    logic               head_valid;
    logic               pop;
    res_t               res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg  <= PAGE_SHIFT_RST;
            page_count_reg  <= PAGE_COUNT_RST;
            phys_frames_reg <= PHYS_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_SHIFT:  page_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_PAGE_COUNT:  page_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_PHYS_FRAMES: phys_frames_reg <= cfg_data[PFC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ptt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .virt_addr       (virt_addr),
        .access_size     (access_size),
        .entry_index     (entry_index),
        .entry_frame     (entry_frame),
        .entry_valid     (entry_valid),
        .entry_read_only (entry_read_only),
        .page_shift      (page_shift_reg),
        .page_count      (page_count_reg),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop)
    );

    ptt_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .head_valid       (head_valid),
        .pop              (pop),
        .page_shift       (page_shift_reg),
        .phys_frame_count (phys_frames_reg),
        .res_valid        (out_valid),
        .res_ready        (out_ready),
        .res              (res)
    );

    assign status        = res.status;
    assign phys_addr     = res.phys_addr;
    assign frame_out     = 16'(res.entry.frame);
    assign valid_out     = res.entry.valid;
    assign read_only_out = res.entry.read_only;
    assign used_out      = res.entry.used;
    assign dirty_out     = res.entry.dirty;

endmodule
`default_nettype wire

// ===== dv/ptt_checker.sv =====
// ----------------------------------------------------------------------------
// ptt_checker
// Watches the word channels and configuration port of the page table
// translator, keeps its own copy of the table and registers, works out the
// result of each accepted input word and compares it with the result words
// in order. Counts failures for the top to judge.
// ----------------------------------------------------------------------------
module ptt_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic [1:0]                       opcode,
    input  wire logic [ptt_pkg::VA_W-1:0]         virt_addr,
    input  wire logic [ptt_pkg::SIZE_W-1:0]       access_size,
    input  wire logic [ptt_pkg::EIDX_W-1:0]       entry_index,
    input  wire logic [ptt_pkg::EFRAME_W-1:0]     entry_frame,
    input  wire logic                             entry_valid,
    input  wire logic                             entry_read_only,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic [2:0]                       status,
    input  wire logic [ptt_pkg::PA_W-1:0]         phys_addr,
    input  wire logic [15:0]                      frame_out,
    input  wire logic                             valid_out,
    input  wire logic                             read_only_out,
    input  wire logic                             used_out,
    input  wire logic                             dirty_out,
    input  wire logic                             cfg_we,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    results_seen,
    output int                                    clean_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam int SHOW_LIMIT = 10;

    pte_t               table_copy [TABLE_DEPTH];
    logic [SHIFT_W-1:0] shift_q;
    logic [COUNT_W-1:0] pages_q;
    logic [PFC_W-1:0]   frames_q;
    res_t               awaited [$];

    int n_fail    = 0;
    int n_pending = 0;
    int n_results = 0;
    int n_clean   = 0;

    assign fail_count   = n_fail;
    assign pending      = n_pending;
    assign results_seen = n_results;
    assign clean_seen   = n_clean;

    // applies one input word to the table copy and returns its result
    function automatic res_t translate(
        input op_t                 op,
        input logic [VA_W-1:0]     va,
        input logic [SIZE_W-1:0]   size,
        input logic [EIDX_W-1:0]   idx,
        input logic [EFRAME_W-1:0] frame,
        input logic                v,
        input logic                ro
    );
        res_t             r;
        logic [63:0]      page;
        logic [63:0]      offset;
        logic [IDX_W-1:0] slot;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_LOAD:
            begin
                if (idx >= TABLE_DEPTH)
                    r.status = ST_ADDR;
                else
                    table_copy[idx] = '{frame: FRAME_BITS'(frame), valid: v,
                                        read_only: ro, used: 1'b0, dirty: 1'b0};
            end
            OP_INSPECT:
            begin
                if (idx >= TABLE_DEPTH)
                    r.status = ST_ADDR;
                else
                    r.entry = table_copy[idx];
            end
            default:
            begin
                page   = 64'(va) >> shift_q;
                offset = 64'(va) & ((64'd1 << shift_q) - 64'd1);
                slot   = page[IDX_W-1:0];
                if (page >= 64'(pages_q) || page >= TABLE_DEPTH)
                    r.status = ST_ADDR;
                else if (!table_copy[slot].valid)
                    r.status = ST_FAULT;
                else if (op == OP_WRITE && table_copy[slot].read_only)
                    r.status = ST_PROT;
                else if (table_copy[slot].frame >= frames_q)
                    r.status = ST_BUS;
                else
                begin
                    // marks are set before the alignment check
                    table_copy[slot].used = 1'b1;
                    if (op == OP_WRITE)
                        table_copy[slot].dirty = 1'b1;
                    if ((size == SZ_HALF && va[0]) || (size >= SZ_WORD && va[1:0] != 2'b00))
                        r.status = ST_ADDR;
                    else
                    begin
                        r.phys_addr = PA_W'((64'(table_copy[slot].frame) << shift_q) + offset);
                        n_clean++;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                table_copy[i] = '0;
            shift_q  = PAGE_SHIFT_RST;
            pages_q  = PAGE_COUNT_RST;
            frames_q = PHYS_FRAMES_RST;
            awaited.delete();
            n_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                got = {status, phys_addr, frame_out, valid_out, read_only_out,
                       used_out, dirty_out};
                if (awaited.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= SHOW_LIMIT)
                        $display("%0t: result word with none awaited: status %0d pa %h",
                                 $time, status, phys_addr);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.status !== want.status || got.phys_addr !== want.phys_addr ||
                        got.entry !== want.entry)
                    begin
                        n_fail++;
                        if (n_fail <= SHOW_LIMIT)
                            $display({"%0t: mismatch (exp/got) status %0d/%0d pa %h/%h ",
                                      "frame %h/%h v %b/%b ro %b/%b use %b/%b dirty %b/%b"},
                                     $time, want.status, got.status, want.phys_addr,
                                     got.phys_addr, want.entry.frame, got.entry.frame,
                                     want.entry.valid, got.entry.valid,
                                     want.entry.read_only, got.entry.read_only,
                                     want.entry.used, got.entry.used,
                                     want.entry.dirty, got.entry.dirty);
                    end
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(translate(op_t'(opcode), virt_addr, access_size,
                                            entry_index, entry_frame, entry_valid,
                                            entry_read_only));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGE_SHIFT:  shift_q  = cfg_data[SHIFT_W-1:0];
                    CFG_PAGE_COUNT:  pages_q  = cfg_data[COUNT_W-1:0];
                    CFG_PHYS_FRAMES: frames_q = cfg_data[PFC_W-1:0];
                    default: ;
                endcase
            end
            n_pending = awaited.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the page table translator: a directed opening,
// then random words over several table settings and idling patterns, and a
// long output hold-off that backs the unit up. Checking is in ptt_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam int PERIOD      = 20;
    localparam int SETTLE      = 4;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_WORDS = 86;
    localparam int PRESS_WORDS = 40;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_WIDE = 2'd3;   // treated as a word

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   in_valid        = 1'b0;
    logic                   in_ready;
    logic [1:0]             opcode          = OP_LOAD;
    logic [VA_W-1:0]        virt_addr       = '0;
    logic [SIZE_W-1:0]      access_size     = SZ_BYTE;
    logic [EIDX_W-1:0]      entry_index     = '0;
    logic [EFRAME_W-1:0]    entry_frame     = '0;
    logic                   entry_valid     = 1'b0;
    logic                   entry_read_only = 1'b0;
    logic                   out_valid;
    logic                   out_ready       = 1'b0;
    logic [2:0]             status;
    logic [PA_W-1:0]        phys_addr;
    logic [15:0]            frame_out;
    logic                   valid_out;
    logic                   read_only_out;
    logic                   used_out;
    logic                   dirty_out;
    logic                   cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index       = CFG_PAGE_SHIFT;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;

    int fail_count;
    int pending;
    int results_seen;
    int clean_seen;

    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   n_sent        = 0;
    int   n_settings    = 0;

    int unsigned cur_shift;
    int unsigned cur_pages;
    int unsigned cur_frames;

    // table settings of the random phases: extremes included
    int unsigned phase_shift  [8] = '{2, 16, 0, 31, 9, 7, 12, 5};
    int unsigned phase_pages  [8] = '{64, 64, 64, 1, 127, 0, 20, 48};
    int unsigned phase_frames [8] = '{65535, 40, 65535, 65535, 0, 32, 300, 1000};

    page_table_translator DUT (.*);

    ptt_checker u_checker (.*);

    always #(PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still awaited", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, or one long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_done <= 1'b1;
                out_ready <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_word(
        input op_t                 op,
        input logic [VA_W-1:0]     va,
        input logic [SIZE_W-1:0]   sz,
        input logic [EIDX_W-1:0]   idx,
        input logic [EFRAME_W-1:0] fr,
        input logic                v,
        input logic                ro
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        virt_addr       <= va;
        access_size     <= sz;
        entry_index     <= idx;
        entry_frame     <= fr;
        entry_valid     <= v;
        entry_read_only <= ro;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    // drop valid and wait for every result word to come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_table(input int unsigned shift, input int unsigned pages,
                             input int unsigned frames);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_SHIFT;
        cfg_data  <= CFG_DATA_W'(shift);
        @(negedge clk);
        cfg_index <= CFG_PAGE_COUNT;
        cfg_data  <= CFG_DATA_W'(pages);
        @(negedge clk);
        cfg_index <= CFG_PHYS_FRAMES;
        cfg_data  <= CFG_DATA_W'(frames);
        @(negedge clk);
        cfg_we     <= 1'b0;
        cur_shift  = shift;
        cur_pages  = pages;
        cur_frames = frames;
        n_settings++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    function automatic logic [VA_W-1:0] page_va(input int pg, input int off);
        return VA_W'((longint'(pg) << cur_shift) + off);
    endfunction

    // mostly well-formed traffic aimed at mapped pages, some noise
    task automatic random_word();
        int unsigned         pick;
        int unsigned         span;
        logic [63:0]         page;
        logic [63:0]         offs;
        logic [63:0]         va64;
        logic [SIZE_W-1:0]   sz;
        logic [EIDX_W-1:0]   idx;
        logic [EFRAME_W-1:0] fr;
        op_t                 op;
        span = (cur_pages < TABLE_DEPTH) ? cur_pages : TABLE_DEPTH;
        pick = $urandom_range(99);
        op   = (pick < 25) ? OP_LOAD : (pick < 55) ? OP_READ :
               (pick < 85) ? OP_WRITE : OP_INSPECT;
        sz   = SIZE_W'($urandom_range(3));
        if (span > 0 && $urandom_range(99) < 85)
            page = $urandom_range(span - 1);
        else
            page = $urandom_range(TABLE_DEPTH + 8);
        offs = {$urandom, $urandom} & ((64'd1 << cur_shift) - 64'd1);
        if ($urandom_range(99) < 65)
            offs = offs & ~64'd3;
        va64 = (page << cur_shift) | offs;
        if ($urandom_range(99) < 8)
            va64 = {32'd0, $urandom};
        if (op == OP_LOAD && span > 0 && $urandom_range(99) < 80)
            idx = EIDX_W'($urandom_range(span - 1));
        else
            idx = EIDX_W'($urandom);
        if (cur_frames > 0 && $urandom_range(99) < 75)
            fr = EFRAME_W'($urandom_range(cur_frames - 1));
        else
            fr = EFRAME_W'($urandom);
        push_word(op, va64[VA_W-1:0], sz, idx, fr,
                  $urandom_range(99) < 85, $urandom_range(99) < 30);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening: 16-byte pages, 8 pages, 16 frames
        set_idling(0);
        set_table(4, 8, 16);
        push_word(OP_INSPECT, '0, SZ_BYTE, 6'd0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(0, 0), SZ_BYTE, '0, '0, 1'b0, 1'b0);
        push_word(OP_LOAD, '0, SZ_BYTE, 6'd0, 16'd3, 1'b1, 1'b0);
        push_word(OP_LOAD, '0, SZ_BYTE, 6'd1, 16'd5, 1'b1, 1'b1);
        push_word(OP_LOAD, '0, SZ_BYTE, 6'd2, 16'd16, 1'b1, 1'b0);
        push_word(OP_LOAD, '0, SZ_BYTE, 6'd3, 16'hFFFF, 1'b0, 1'b1);
        push_word(OP_LOAD, '0, SZ_BYTE, 6'd63, 16'hFFFF, 1'b1, 1'b1);
        push_word(OP_READ, page_va(0, 5), SZ_BYTE, '0, '0, 1'b0, 1'b0);
        push_word(OP_WRITE, page_va(0, 2), SZ_HALF, '0, '0, 1'b0, 1'b0);
        push_word(OP_WRITE, page_va(1, 0), SZ_WORD, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(1, 12), SZ_WORD, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(2, 0), SZ_BYTE, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(3, 0), SZ_BYTE, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(8, 0), SZ_BYTE, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, '1, SZ_BYTE, '1, '1, 1'b1, 1'b1);
        // reload clears the marks; misaligned accesses still set them
        push_word(OP_LOAD, '0, SZ_BYTE, 6'd0, 16'd3, 1'b1, 1'b0);
        push_word(OP_READ, page_va(0, 1), SZ_HALF, '0, '0, 1'b0, 1'b0);
        push_word(OP_INSPECT, '0, SZ_BYTE, 6'd0, '0, 1'b0, 1'b0);
        push_word(OP_WRITE, page_va(0, 6), SZ_WORD, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(0, 8), SZ_WIDE, '0, '0, 1'b0, 1'b0);
        push_word(OP_READ, page_va(0, 9), SZ_WIDE, '0, '0, 1'b0, 1'b0);
        push_word(OP_INSPECT, '0, SZ_BYTE, 6'd0, '0, 1'b0, 1'b0);
        push_word(OP_INSPECT, '0, SZ_BYTE, 6'd1, '0, 1'b0, 1'b0);
        push_word(OP_INSPECT, '0, SZ_BYTE, 6'd2, '0, 1'b0, 1'b0);
        push_word(OP_INSPECT, '0, SZ_BYTE, 6'd63, '0, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            set_table(phase_shift[p], phase_pages[p], phase_frames[p]);
            set_idling(p % 4);
            repeat (PHASE_WORDS) random_word();
            drain();
        end

        // back the unit up behind a long output hold-off
        set_table(4, 64, 65535);
        set_idling(0);
        hold_req <= 1'b1;
        repeat (PRESS_WORDS) random_word();
        drain();

        $display("covered %0d words over %0d table settings, with input gaps, output stalls",
                 n_sent, n_settings);
        $display("and a long hold-off; %0d results compared, %0d clean translations",
                 results_seen, clean_seen);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ptt_pkg.sv
sv/ptt_ram.sv
sv/ptt_front.sv
sv/ptt_back.sv
sv/page_table_translator.sv
dv/ptt_checker.sv
dv/tb_top.sv
